>>> hdl/strip_hit_clusterer_centroid_core_defines.svh
// Assertion macros for the strip hit clusterer core.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef STRIP_HIT_CLUSTERER_CENTROID_CORE_DEFINES_SVH
`define STRIP_HIT_CLUSTERER_CENTROID_CORE_DEFINES_SVH

// Same-cycle implication.
`define SCC_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("strip clusterer check failed");

// Next-cycle implication.
`define SCC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("strip clusterer check failed");

`endif

>>> hdl/scc_pkg.sv
// Shared types and constants for the strip hit clusterer core.
// No dependencies.
package scc_pkg;

	localparam int MAX_STRIPS_DEF   = 64;
	localparam int CHANNEL_BITS_DEF = 13;

	localparam int GAP_W        = 3;
	localparam int CHARGE_W     = 16;
	localparam int POS_W        = 21;
	localparam int HOLE_W       = 4;
	localparam int SIZE_W       = 7;
	localparam int COUNT_OUT_W  = 7;
	localparam int CHARGE_OUT_W = 22;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE = 1'd1;

	localparam logic [HOLE_W-1:0] HOLE_RST = 4'd1;
	localparam logic [SIZE_W-1:0] SIZE_RST = 7'd50;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ADD,
		ST_LAST,
		ST_DIV,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic fresh;
		logic div_start;
		logic srch_start;
		logic srch_step;
		logic emit;
		logic end_flag;
		logic close;
	} cmd_t;

	typedef struct packed {
		logic open;
		logic brk;
		logic closeable;
		logic last;
		logic div_done;
		logic srch_done;
		logic out_free;
	} sts_t;

endpackage

>>> hdl/scc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by scc_datapath.
module scc_div #(
	parameter int W  = 44,
	parameter int DW = 23
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic [W-1:0]  quotient,
	output logic          done
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [W-1:0]     quo_q;
	logic [DW:0]      r_ext;
	logic             take;

	assign done     = (cnt_q == CNT_W'(W));
	assign quotient = quo_q;
	assign r_ext    = {rem_q, quo_q[W-1]};
	assign take     = (r_ext >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(W);
		end else if (start) begin
			cnt_q <= '0;
		end else if (!done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (!done) begin
			rem_q <= take ? DW'(r_ext - {1'b0, div_q}) : r_ext[DW-1:0];
			quo_q <= {quo_q[W-2:0], take};
		end
	end

endmodule

>>> hdl/scc_datapath.sv
// Datapath: hit register, accumulators, channel store, dividers, search, result register.
// Depends on scc_pkg and scc_div.
module scc_datapath #(
	parameter int MAX_STRIPS   = scc_pkg::MAX_STRIPS_DEF,
	parameter int CHANNEL_BITS = scc_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  scc_pkg::cmd_t                       cmd,
	output scc_pkg::sts_t                       sts,
	input  logic                                cfg_we,
	input  logic [scc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [scc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [scc_pkg::GAP_W-1:0]           gas_gap,
	input  logic [CHANNEL_BITS-1:0]             channel,
	input  logic [scc_pkg::CHARGE_W-1:0]        charge,
	input  logic signed [scc_pkg::POS_W-1:0]    pos_x,
	input  logic signed [scc_pkg::POS_W-1:0]    pos_y,
	input  logic                                last_in_collection,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [scc_pkg::GAP_W-1:0]           cluster_gap,
	output logic [CHANNEL_BITS-1:0]             first_strip,
	output logic [scc_pkg::COUNT_OUT_W-1:0]     strip_count,
	output logic [CHANNEL_BITS-1:0]             centre_strip,
	output logic [scc_pkg::CHARGE_OUT_W-1:0]    charge_total,
	output logic signed [scc_pkg::POS_W-1:0]    centroid_x,
	output logic signed [scc_pkg::POS_W-1:0]    cluster_y,
	output logic                                zero_charge,
	output logic                                collection_end
);

	localparam int AW     = $clog2(MAX_STRIPS);
	localparam int CW     = $clog2(MAX_STRIPS + 2);
	localparam int SW     = CHANNEL_BITS + CW;
	localparam int CQ_W   = scc_pkg::CHARGE_W + CW;
	localparam int PROD_W = scc_pkg::POS_W + scc_pkg::CHARGE_W + 1;
	localparam int WX_W   = scc_pkg::POS_W + scc_pkg::CHARGE_W + CW;
	localparam int CMPW   = (CW > scc_pkg::SIZE_W) ? CW : scc_pkg::SIZE_W;
	localparam int CQX    = (CQ_W > scc_pkg::CHARGE_OUT_W) ? CQ_W : scc_pkg::CHARGE_OUT_W;

	// configuration
	logic [scc_pkg::HOLE_W-1:0] max_hole_q;
	logic [scc_pkg::SIZE_W-1:0] max_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hole_q <= scc_pkg::HOLE_RST;
			max_size_q <= scc_pkg::SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				scc_pkg::REG_MAX_HOLE: max_hole_q <= cfg_data[scc_pkg::HOLE_W-1:0];
				scc_pkg::REG_MAX_SIZE: max_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched hit
	logic [scc_pkg::GAP_W-1:0]        hit_gap_q;
	logic [CHANNEL_BITS-1:0]          hit_ch_q;
	logic [scc_pkg::CHARGE_W-1:0]     hit_q_q;
	logic signed [scc_pkg::POS_W-1:0] hit_x_q;
	logic signed [scc_pkg::POS_W-1:0] hit_y_q;
	logic                             hit_last_q;
	logic signed [PROD_W-1:0]         prod_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit_gap_q  <= gas_gap;
			hit_ch_q   <= channel;
			hit_q_q    <= charge;
			hit_x_q    <= pos_x;
			hit_y_q    <= pos_y;
			hit_last_q <= last_in_collection;
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(hit_x_q) * PROD_W'($signed({1'b0, hit_q_q}));
		end
	end

	// cluster state
	logic                             open_q;
	logic [scc_pkg::GAP_W-1:0]        gap_q;
	logic [CHANNEL_BITS-1:0]          prev_q;
	logic [CHANNEL_BITS-1:0]          first_ch_q;
	logic [CW-1:0]                    cnt_q;
	logic [CQ_W-1:0]                  charge_q;
	logic signed [WX_W-1:0]           wx_q;
	logic [SW-1:0]                    sum_q;
	logic signed [scc_pkg::POS_W-1:0] first_y_q;
	logic [CHANNEL_BITS-1:0]          store [MAX_STRIPS];

	logic [CW-1:0]          base_cnt;
	logic [CQ_W-1:0]        base_charge;
	logic signed [WX_W-1:0] base_wx;
	logic [SW-1:0]          base_sum;
	logic [CHANNEL_BITS-1:0] diff;

	always_comb begin
		base_cnt    = cmd.fresh ? '0 : cnt_q;
		base_charge = cmd.fresh ? '0 : charge_q;
		base_wx     = cmd.fresh ? '0 : wx_q;
		base_sum    = cmd.fresh ? '0 : sum_q;
		diff        = (hit_ch_q > prev_q) ? (hit_ch_q - prev_q) : (prev_q - hit_ch_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.add) begin
			open_q <= 1'b1;
			cnt_q  <= (base_cnt < CW'(MAX_STRIPS)) ? base_cnt + 1'b1 : CW'(MAX_STRIPS + 1);
		end else if (cmd.close) begin
			open_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			prev_q <= hit_ch_q;
			if (cmd.fresh) begin
				gap_q      <= hit_gap_q;
				first_ch_q <= hit_ch_q;
				first_y_q  <= hit_y_q;
			end
			if (base_cnt < CW'(MAX_STRIPS)) begin
				store[base_cnt[AW-1:0]] <= hit_ch_q;
				charge_q <= base_charge + CQ_W'(hit_q_q);
				wx_q     <= base_wx + WX_W'(prod_s1);
				sum_q    <= base_sum + SW'(hit_ch_q);
			end
		end
	end

	// dividers
	logic [WX_W-1:0] wx_mag;
	logic [WX_W-1:0] cx_quo;
	logic [SW-1:0]   mean;
	logic            cx_done;
	logic            mean_done;
	logic            sign_q;

	assign wx_mag = wx_q[WX_W-1] ? WX_W'(-wx_q) : WX_W'(wx_q);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sign_q <= wx_q[WX_W-1];
		end
	end

	scc_div #(.W(WX_W), .DW(CQ_W)) u_cx_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (wx_mag),
		.divisor  (charge_q),
		.quotient (cx_quo),
		.done     (cx_done)
	);

	scc_div #(.W(SW), .DW(CW)) u_mean_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.quotient (mean),
		.done     (mean_done)
	);

	// store search for the mean channel
	logic [CW-1:0]           idx_q;
	logic                    look_s1;
	logic                    found_q;
	logic [CHANNEL_BITS-1:0] rd_q;
	logic [CHANNEL_BITS-1:0] centre_q;

	always_ff @(posedge clk) begin
		rd_q <= store[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			look_s1 <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.srch_start) begin
			idx_q   <= '0;
			look_s1 <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.srch_step && !found_q) begin
			if (idx_q < cnt_q) begin
				idx_q   <= idx_q + 1'b1;
				look_s1 <= 1'b1;
			end else begin
				look_s1 <= 1'b0;
			end
			if (look_s1 && (SW'(rd_q) == mean)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_step && !found_q && look_s1 && (SW'(rd_q) == mean)) begin
			centre_q <= rd_q;
		end
	end

	// result register
	logic [CMPW-1:0]  cnt_ext;
	logic [CQX-1:0]   charge_ext;
	logic [WX_W-1:0]  cx_signed;

	assign cnt_ext    = CMPW'(cnt_q);
	assign charge_ext = CQX'(charge_q);
	assign cx_signed  = sign_q ? -cx_quo : cx_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cluster_gap    <= gap_q;
			first_strip    <= first_ch_q;
			strip_count    <= cnt_ext[scc_pkg::COUNT_OUT_W-1:0];
			centre_strip   <= found_q ? centre_q : first_ch_q;
			charge_total   <= charge_ext[scc_pkg::CHARGE_OUT_W-1:0];
			centroid_x     <= (charge_q == '0) ? '0 : $signed(cx_signed[scc_pkg::POS_W-1:0]);
			cluster_y      <= first_y_q;
			zero_charge    <= (charge_q == '0);
			collection_end <= cmd.end_flag;
		end
	end

	// status
	always_comb begin
		sts.open      = open_q;
		sts.brk       = open_q && ((hit_gap_q != gap_q)
			|| (diff > CHANNEL_BITS'(max_hole_q) + 1'b1));
		sts.closeable = (cnt_q != '0) && (cnt_q <= CW'(MAX_STRIPS))
			&& (cnt_ext <= CMPW'(max_size_q));
		sts.last      = hit_last_q;
		sts.div_done  = cx_done && mean_done;
		sts.srch_done = found_q || ((idx_q == cnt_q) && !look_s1);
		sts.out_free  = !out_valid || !out_stall;
	end

endmodule

>>> hdl/scc_ctrl.sv
// Controller state machine for the strip hit clusterer core.
// Depends on scc_pkg.
module scc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  scc_pkg::sts_t sts,
	output scc_pkg::cmd_t cmd
);

	scc_pkg::state_t state_q, state_d;
	logic end_q, end_d;
	logic fresh_q, fresh_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::ST_IDLE;
			end_q   <= 1'b0;
			fresh_q <= 1'b0;
		end else begin
			state_q <= state_d;
			end_q   <= end_d;
			fresh_q <= fresh_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		end_d    = end_q;
		fresh_d  = fresh_q;
		cmd      = '0;
		cmd.fresh    = fresh_q;
		cmd.end_flag = end_q;
		in_stall = (state_q != scc_pkg::ST_IDLE);
		case (state_q)
			scc_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = scc_pkg::ST_EVAL;
				end
			end
			scc_pkg::ST_EVAL: begin
				cmd.mul = 1'b1;
				fresh_d = !sts.open || sts.brk;
				if (sts.brk && sts.closeable) begin
					cmd.div_start = 1'b1;
					end_d   = 1'b0;
					state_d = scc_pkg::ST_DIV;
				end else begin
					state_d = scc_pkg::ST_ADD;
				end
			end
			scc_pkg::ST_ADD: begin
				cmd.add = 1'b1;
				state_d = scc_pkg::ST_LAST;
			end
			scc_pkg::ST_LAST: begin
				if (sts.last && sts.closeable) begin
					cmd.div_start = 1'b1;
					end_d   = 1'b1;
					state_d = scc_pkg::ST_DIV;
				end else begin
					// drop an oversized final cluster, still close it
					cmd.close = sts.last;
					state_d   = scc_pkg::ST_IDLE;
				end
			end
			scc_pkg::ST_DIV: begin
				if (sts.div_done) begin
					cmd.srch_start = 1'b1;
					state_d = scc_pkg::ST_SEARCH;
				end
			end
			scc_pkg::ST_SEARCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_done) begin
					state_d = scc_pkg::ST_EMIT;
				end
			end
			scc_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (end_q) begin
						cmd.close = 1'b1;
						state_d   = scc_pkg::ST_IDLE;
					end else begin
						state_d = scc_pkg::ST_ADD;
					end
				end
			end
			default: begin
				state_d = scc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/strip_hit_clusterer_centroid_core.sv
// Top level of the strip hit clusterer with charge-weighted centroid.
// Depends on scc_pkg, scc_ctrl, scc_datapath and the defines header.
//
//   port group   direction   handshake            payload
//   in           sink        in_valid/in_stall    gas_gap .. last_in_collection
//   out          source      out_valid/out_stall  cluster_gap .. collection_end
//   cfg          sink        cfg_we               cfg_index, cfg_data
//
// An item that closes no cluster goes through latch, multiply, accumulate and
// last check. Each emitted cluster adds the bit-serial divide over the bits of
// the weighted-x sum (21 + 16 + clog2(MAX_STRIPS+2) bits, 44 by default), then
// a scan of the channel store and the load of the result register. Reset
// clears control state and sets the configuration to its defaults; the
// channel store needs no clearing. A stalled result holds in the output
// register while the next item is taken; only a further result waits for it.
`include "strip_hit_clusterer_centroid_core_defines.svh"

module strip_hit_clusterer_centroid_core #(
	parameter int MAX_STRIPS   = scc_pkg::MAX_STRIPS_DEF,
	parameter int CHANNEL_BITS = scc_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [scc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [scc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [scc_pkg::GAP_W-1:0]           gas_gap,
	input  logic [CHANNEL_BITS-1:0]             channel,
	input  logic [scc_pkg::CHARGE_W-1:0]        charge,
	input  logic signed [scc_pkg::POS_W-1:0]    pos_x,
	input  logic signed [scc_pkg::POS_W-1:0]    pos_y,
	input  logic                                last_in_collection,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [scc_pkg::GAP_W-1:0]           cluster_gap,
	output logic [CHANNEL_BITS-1:0]             first_strip,
	output logic [scc_pkg::COUNT_OUT_W-1:0]     strip_count,
	output logic [CHANNEL_BITS-1:0]             centre_strip,
	output logic [scc_pkg::CHARGE_OUT_W-1:0]    charge_total,
	output logic signed [scc_pkg::POS_W-1:0]    centroid_x,
	output logic signed [scc_pkg::POS_W-1:0]    cluster_y,
	output logic                                zero_charge,
	output logic                                collection_end
);

	scc_pkg::cmd_t cmd;
	scc_pkg::sts_t sts;

	// sequence each item: join or break, accumulate, close and emit
	scc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the open cluster, divide, search the store, drive results
	scc_datapath #(
		.MAX_STRIPS   (MAX_STRIPS),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.gas_gap            (gas_gap),
		.channel            (channel),
		.charge             (charge),
		.pos_x              (pos_x),
		.pos_y              (pos_y),
		.last_in_collection (last_in_collection),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.cluster_gap        (cluster_gap),
		.first_strip        (first_strip),
		.strip_count        (strip_count),
		.centre_strip       (centre_strip),
		.charge_total       (charge_total),
		.centroid_x         (centroid_x),
		.cluster_y          (cluster_y),
		.zero_charge        (zero_charge),
		.collection_end     (collection_end)
	);

	// one item at a time: busy right after taking one
	`SCC_ASSERT_NEXT(a_busy_after_item, in_valid && !in_stall, in_stall)
	// an emitted cluster always holds a strip
	`SCC_ASSERT_NOW(a_count_nonzero, out_valid, strip_count != '0)
	// zero charge forces the centroid to zero
	`SCC_ASSERT_NOW(a_zero_centroid, out_valid && zero_charge, centroid_x == '0)

endmodule

>>> tb/tb_top.sv
// Self-checking bench for the strip hit clusterer core: random and directed strip hits,
// predicted clusters compared field by field. Depends on scc_pkg and the core RTL.
module tb_top;

	localparam int MAXS   = scc_pkg::MAX_STRIPS_DEF;
	localparam int CHW    = scc_pkg::CHANNEL_BITS_DEF;
	localparam int GAPW   = scc_pkg::GAP_W;
	localparam int QW     = scc_pkg::CHARGE_W;
	localparam int PW     = scc_pkg::POS_W;
	localparam int CNTW   = scc_pkg::COUNT_OUT_W;
	localparam int TOTW   = scc_pkg::CHARGE_OUT_W;
	localparam int IDXW   = scc_pkg::CFG_IDX_W;
	localparam int DATW   = scc_pkg::CFG_DATA_W;
	localparam int SETTLE = 250;   // longer than a cluster's item steps, divide, scan and result load
	localparam int HOLD   = 1500;  // long receiver hold-off to back up the core

	typedef struct {
		logic [GAPW-1:0]            gap;
		logic [CHW-1:0]             ch;
		logic [QW-1:0]              q;
		logic signed [PW-1:0]       x;
		logic signed [PW-1:0]       y;
		logic                       last;
	} hit_t;

	typedef struct {
		logic [GAPW-1:0]            gap;
		logic [CHW-1:0]             first;
		logic [CNTW-1:0]            count;
		logic [CHW-1:0]             centre;
		logic [TOTW-1:0]            total;
		logic signed [PW-1:0]       cx;
		logic signed [PW-1:0]       y;
		logic                       zero;
		logic                       fin;
	} cluster_t;

	// Cluster predictor plus the queue of clusters still owed by the core.
	class cluster_board;
		cluster_t    owed_q[$];
		int unsigned hole_lim, size_lim;
		bit          open;
		int unsigned open_gap, prev_ch, hits, q_sum, ch_sum;
		longint      wx_sum, first_y;
		int unsigned store[MAXS];
		int unsigned made, dropped;

		function new();
			hole_lim = scc_pkg::HOLE_RST;
			size_lim = scc_pkg::SIZE_RST;
			open = 0;
			hits = 0;
		endfunction

		function void set_reg(logic [IDXW-1:0] idx, int unsigned v);
			if (idx == scc_pkg::REG_MAX_HOLE) hole_lim = v & 15;
			else size_lim = v & 127;
		endfunction

		function void close_open(bit ending);
			cluster_t    c;
			int unsigned mean, centre;
			longint      cx;
			if (hits == 0 || hits > MAXS || hits > size_lim) begin
				if (hits != 0) dropped++;
				return;
			end
			mean = ch_sum / hits;
			centre = store[0];
			for (int k = 0; k < hits; k++) begin
				if (store[k] == mean) begin
					centre = store[k];
					break;
				end
			end
			cx = 0;
			if (q_sum != 0) cx = wx_sum / longint'(q_sum);
			c.gap = GAPW'(open_gap);
			c.first = CHW'(store[0]);
			c.count = CNTW'(hits);
			c.centre = CHW'(centre);
			c.total = TOTW'(q_sum);
			c.cx = PW'(cx);
			c.y = PW'(first_y);
			c.zero = (q_sum == 0);
			c.fin = ending;
			owed_q.insert(owed_q.size(), c);
			made++;
		endfunction

		function void note_hit(hit_t h);
			int unsigned d;
			if (open) begin
				d = (h.ch > prev_ch) ? h.ch - prev_ch : prev_ch - h.ch;
				if (h.gap != open_gap || d > hole_lim + 1) begin
					close_open(0);
					open = 0;
				end
			end
			if (!open) begin
				open_gap = h.gap;
				hits = 0;
				q_sum = 0;
				wx_sum = 0;
				ch_sum = 0;
				first_y = h.y;
			end
			if (hits < MAXS) begin
				store[hits] = h.ch;
				q_sum += h.q;
				wx_sum += longint'(h.x) * longint'(h.q);
				ch_sum += h.ch;
				hits++;
			end else begin
				hits = MAXS + 1;
			end
			prev_ch = h.ch;
			open = 1;
			if (h.last) begin
				close_open(1);
				open = 0;
			end
		endfunction

		function string check_result(cluster_t got);
			cluster_t e;
			string    m;
			if (owed_q.size() == 0) return "cluster with none expected";
			e = owed_q.pop_front();
			m = "";
			if (got.gap !== e.gap) m = {m, $sformatf(" gap %0d/%0d", got.gap, e.gap)};
			if (got.first !== e.first) m = {m, $sformatf(" first %0d/%0d", got.first, e.first)};
			if (got.count !== e.count) m = {m, $sformatf(" count %0d/%0d", got.count, e.count)};
			if (got.centre !== e.centre)
				m = {m, $sformatf(" centre %0d/%0d", got.centre, e.centre)};
			if (got.total !== e.total) m = {m, $sformatf(" charge %0d/%0d", got.total, e.total)};
			if (got.cx !== e.cx) m = {m, $sformatf(" x %0d/%0d", got.cx, e.cx)};
			if (got.y !== e.y) m = {m, $sformatf(" y %0d/%0d", got.y, e.y)};
			if (got.zero !== e.zero) m = {m, $sformatf(" zero %b/%b", got.zero, e.zero)};
			if (got.fin !== e.fin) m = {m, $sformatf(" end %b/%b", got.fin, e.fin)};
			if (m != "") m = {"field mismatch (got/exp):", m};
			return m;
		endfunction
	endclass

	logic                         clk, arst_n;
	logic                         cfg_we;
	logic [IDXW-1:0]              cfg_index;
	logic [DATW-1:0]              cfg_data;
	logic                         in_valid, in_stall;
	logic [GAPW-1:0]              gas_gap;
	logic [CHW-1:0]               channel;
	logic [QW-1:0]                charge;
	logic signed [PW-1:0]         pos_x, pos_y;
	logic                         last_in_collection;
	logic                         out_valid, out_stall;
	logic [GAPW-1:0]              cluster_gap;
	logic [CHW-1:0]               first_strip, centre_strip;
	logic [CNTW-1:0]              strip_count;
	logic [TOTW-1:0]              charge_total;
	logic signed [PW-1:0]         centroid_x, cluster_y;
	logic                         zero_charge, collection_end;

	cluster_board board;
	int unsigned  errors, checked, hits_sent, settings;
	bit           hold_req, hold_on;

	strip_hit_clusterer_centroid_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.gas_gap(gas_gap), .channel(channel), .charge(charge),
		.pos_x(pos_x), .pos_y(pos_y), .last_in_collection(last_in_collection),
		.out_valid(out_valid), .out_stall(out_stall),
		.cluster_gap(cluster_gap), .first_strip(first_strip), .strip_count(strip_count),
		.centre_strip(centre_strip), .charge_total(charge_total),
		.centroid_x(centroid_x), .cluster_y(cluster_y),
		.zero_charge(zero_charge), .collection_end(collection_end)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the whole run, far above the slowest legal schedule.
	initial begin
		#40_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic report(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Gap length before the next item: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one hit and hold it until the core takes it. Called right after a rising edge.
	task automatic send_hit(hit_t h, int gap);
		bit taken;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		gas_gap <= h.gap;
		channel <= h.ch;
		charge <= h.q;
		pos_x <= h.x;
		pos_y <= h.y;
		last_in_collection <= h.last;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		board.note_hit(h);
		hits_sent++;
	endtask

	task automatic send_fixed(int g, int ch, int q, int x, int y, bit last);
		hit_t h;
		h.gap = GAPW'(g);
		h.ch = CHW'(ch);
		h.q = QW'(q);
		h.x = PW'(x);
		h.y = PW'(y);
		h.last = last;
		send_hit(h, pick_gap());
	endtask

	// Drop valid and let every owed cluster come out, then let the core go quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.owed_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDXW-1:0] idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DATW'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, v);
	endtask

	// One collection of n hits closed by a last hit. Well-formed collections walk up
	// the channels within reach, with occasional gap changes, breaks and backward steps;
	// noise collections are fully random. Steady ones never break (long clusters).
	task automatic gen_collection(int n, bit noise, bit steady);
		hit_t        h;
		int unsigned g, ch, r, rq;
		bit          zq;
		g = $urandom_range(0, 7);
		ch = steady ? $urandom_range(0, 4000) : $urandom_range(0, 8191);
		zq = ($urandom_range(0, 9) == 0);
		for (int k = 0; k < n; k++) begin
			if (noise) begin
				g = $urandom_range(0, 7);
				ch = $urandom_range(0, 8191);
			end else if (k > 0) begin
				r = $urandom_range(0, 99);
				if (steady) ch += $urandom_range(1, board.hole_lim + 1);
				else if (r < 8 && g < 7) begin
					g++;
					ch = $urandom_range(0, 8191);
				end else if (r < 16) ch += board.hole_lim + 2 + $urandom_range(0, 20);
				else if (r < 20) ch = (ch > board.hole_lim + 1) ?
					ch - $urandom_range(0, board.hole_lim + 1) : ch;
				else ch += $urandom_range(1, board.hole_lim + 1);
				if (ch > 8191) ch = $urandom_range(0, 8191);
			end
			rq = $urandom_range(0, 99);
			h.gap = GAPW'(g);
			h.ch = CHW'(ch);
			h.q = zq ? '0 : (rq < 5 ? '0 : (rq < 10 ? '1 : QW'($urandom_range(0, 65535))));
			h.x = PW'($urandom_range(0, 32'h1FFFFF));
			h.y = PW'($urandom_range(0, 32'h1FFFFF));
			h.last = (k == n - 1) || (noise && $urandom_range(0, 19) == 0);
			send_hit(h, pick_gap());
		end
	endtask

	// Receiver: random stall bursts, quiet stretches, and one long hold on request.
	initial begin
		int r, len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				hold_on = 1;
				repeat (HOLD) @(posedge clk);
				hold_req = 0;
				hold_on = 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					out_stall <= 1'b0;
					len = $urandom_range(1, 8);
				end else if (r < 75) begin
					out_stall <= 1'b1;
					len = $urandom_range(1, 3);
				end else if (r < 92) begin
					out_stall <= 1'b0;
					len = $urandom_range(20, 60);
				end else begin
					out_stall <= 1'b1;
					len = $urandom_range(20, 80);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	// Sample results at the falling edge before the edge that takes them.
	initial begin
		cluster_t c;
		string    msg;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				c.gap = cluster_gap;
				c.first = first_strip;
				c.count = strip_count;
				c.centre = centre_strip;
				c.total = charge_total;
				c.cx = centroid_x;
				c.y = cluster_y;
				c.zero = zero_charge;
				c.fin = collection_end;
				msg = board.check_result(c);
				if (msg != "") report(msg);
				else checked++;
			end
		end
	end

	initial begin
		int unsigned holes[7] = '{0, 15, 3, 1, 2, 7, 1};
		int unsigned sizes[7] = '{1, 64, 8, 0, 127, 20, 50};
		int          budget, n, r;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = scc_pkg::REG_MAX_HOLE;
		cfg_data = '0;
		in_valid = 1'b0;
		gas_gap = '0;
		channel = '0;
		charge = '0;
		pos_x = '0;
		pos_y = '0;
		last_in_collection = 1'b0;
		hold_req = 0;
		hold_on = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings (hole 1, size 50).
		send_fixed(0, 0, 65535, 1048575, -1048576, 1);      // lone strip, extreme positions
		send_fixed(7, 8191, 0, -1048576, 1048575, 1);       // zero charge, top channel
		send_fixed(2, 100, 1000, 5000, 77, 0);
		send_fixed(2, 101, 3000, -2000, 78, 0);
		send_fixed(2, 103, 500, 9000, 79, 0);               // hole of one still joins
		send_fixed(2, 106, 800, 100, 80, 1);                // break plus flush: two clusters
		send_fixed(3, 200, 10, -7, 5, 0);
		send_fixed(4, 201, 20, -9, 6, 1);                   // gap change closes the cluster
		send_fixed(5, 300, 40, 3, 1, 0);
		send_fixed(5, 299, 50, -3, 2, 0);                   // backward step within reach
		send_fixed(5, 301, 60, 11, 3, 1);
		send_fixed(1, 10, 1, 1, 0, 0);
		send_fixed(1, 12, 1, -1, 0, 1);                     // mean channel not in cluster
		send_fixed(1, 20, 7, 100, 0, 0);
		send_fixed(1, 21, 7, -100, 0, 0);
		send_fixed(1, 22, 0, 33, 0, 1);                     // centre found at mean
		send_fixed(6, 400, 0, 12345, -9, 0);
		send_fixed(6, 400, 0, -54321, -9, 1);               // duplicate channel, zero charge
		send_fixed(0, 8190, 65535, -1048576, 0, 0);
		send_fixed(0, 8191, 65535, -1048576, 0, 1);         // negative centroid
		drain();

		// Random phases, each under its own register setting.
		for (int p = 0; p < 7; p++) begin
			write_reg(scc_pkg::REG_MAX_HOLE, holes[p]);
			write_reg(scc_pkg::REG_MAX_SIZE, sizes[p]);
			settings++;
			budget = hits_sent + 275;
			if (p == 2) begin
				// Back the core up: long receiver hold while hits keep coming.
				hold_req = 1;
				wait (hold_on);
				for (int k = 0; k < 60; k++)
					send_fixed($urandom_range(0, 7), $urandom_range(0, 8191),
						$urandom_range(0, 65535), $urandom_range(0, 32'h1FFFFF),
						$urandom_range(0, 32'h1FFFFF), k % 3 == 2);
			end
			while (hits_sent < budget) begin
				r = $urandom_range(0, 99);
				if (r < 4) gen_collection($urandom_range(MAXS - 2, MAXS + 3), 0, 1);
				else if (r < 14) gen_collection($urandom_range(1, 8), 1, 0);
				else begin
					n = (r < 50) ? $urandom_range(1, 4) : $urandom_range(2, 14);
					gen_collection(n, 0, 0);
				end
			end
			drain();
		end

		$display("Covered %0d hits over %0d register settings plus reset defaults.",
			hits_sent, settings);
		$display("Checked %0d clusters; %0d were dropped by the size limits.",
			checked, board.dropped);
		if (errors == 0 && board.owed_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
